/* design/cpra_pkg.sv */
// Shared constants, codes and types of the contiguous page run allocator.
package cpra_pkg;

  // Page map geometry; NUM_PAGES is a power of two.
  localparam int NUM_PAGES = 65536;
  localparam int ROW_W     = 32;
  localparam int BIT_W     = $clog2(ROW_W);
  localparam int NUM_ROWS  = NUM_PAGES / ROW_W;
  localparam int ROW_AW    = $clog2(NUM_ROWS);
  localparam int PIDX_W    = $clog2(NUM_PAGES);

  // Field widths of the beats.
  localparam int OP_W   = 2;
  localparam int PAGE_W = 16;
  localparam int CNT_W  = 16;
  localparam int CFG_W  = 16;

  // Page pointers carry one bit more than any page index so they can run past the end.
  localparam int PTR_W = ((PIDX_W > PAGE_W) ? PIDX_W : PAGE_W) + 1;
  localparam int RUN_W = CNT_W + 1;

  localparam int IN_TDATA_W  = ((OP_W + PAGE_W + CNT_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((1 + PAGE_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] SCAN_START_RESET = CFG_W'(4096);

  localparam logic STATUS_DONE     = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOCATE = 2'd0,
    OP_FREE     = 2'd1,
    OP_MARK     = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_SET_RD,
    ST_SET_LD,
    ST_SET,
    ST_SET_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_addr;
    logic [ROW_W-1:0]  wr_data;
  } map_req_t;

  typedef struct packed {
    logic              status;
    logic [PAGE_W-1:0] first_page;
  } result_t;

endpackage

/* design/cpra_map_ram.sv */
// Present map storage: one row of page bits per word, registered read.
module cpra_map_ram
  import cpra_pkg::*;
(
  input  logic             clk,
  input  map_req_t         req,
  output logic [ROW_W-1:0] rd_data
);

  logic [ROW_W-1:0] mem [NUM_ROWS];
  logic [ROW_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/cpra_ctrl.sv */
// Sequencer: clears map by rows, scans and updates one page per cycle, pausing per row.
module cpra_ctrl
  import cpra_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [PAGE_W-1:0] in_start,
  input  logic [CNT_W-1:0]  in_count,
  input  logic [CFG_W-1:0]  scan_start,
  output map_req_t          map_req,
  input  logic [ROW_W-1:0]  map_rd_data,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  state_t            state_r,   state_nxt;
  logic [ROW_AW-1:0] clr_r,     clr_nxt;
  logic [PTR_W-1:0]  ptr_r,     ptr_nxt;
  logic [PTR_W-1:0]  end_r,     end_nxt;
  logic [PTR_W-1:0]  cand_r,    cand_nxt;
  logic [RUN_W-1:0]  run_r,     run_nxt;
  logic [RUN_W-1:0]  need_r,    need_nxt;
  logic [CNT_W-1:0]  cnt_r,     cnt_nxt;
  logic [ROW_W-1:0]  row_r,     row_nxt;
  logic [ROW_AW-1:0] wr_row_r,  wr_row_nxt;
  logic              set_bit_r, set_bit_nxt;
  logic              status_r,  status_nxt;
  logic [PAGE_W-1:0] first_r,   first_nxt;

  logic [PTR_W-1:0]  ptr_inc;
  logic [PTR_W-1:0]  in_end;
  logic [PTR_W-1:0]  start_ext;
  logic [PTR_W-1:0]  scan_ext;
  logic [PTR_W-1:0]  map_end;
  logic [BIT_W-1:0]  bit_sel;
  logic [ROW_AW-1:0] ptr_row;
  logic [RUN_W-1:0]  run_inc;
  logic              cur_bit;
  logic              row_last;
  logic              walk_end;

  assign map_end   = PTR_W'(NUM_PAGES);
  assign ptr_inc   = ptr_r + PTR_W'(1);
  assign start_ext = PTR_W'(in_start);
  assign scan_ext  = PTR_W'(scan_start);
  assign in_end    = start_ext + PTR_W'(in_count);
  assign bit_sel   = ptr_r[BIT_W-1:0];
  assign ptr_row   = ptr_r[PIDX_W-1:BIT_W];
  assign row_last  = &bit_sel;
  assign cur_bit   = map_rd_data[bit_sel];
  assign run_inc   = run_r + RUN_W'(1);
  assign walk_end  = (ptr_r >= end_r) || (ptr_r >= map_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    end_r     <= end_nxt;
    cand_r    <= cand_nxt;
    run_r     <= run_nxt;
    need_r    <= need_nxt;
    cnt_r     <= cnt_nxt;
    row_r     <= row_nxt;
    wr_row_r  <= wr_row_nxt;
    set_bit_r <= set_bit_nxt;
    status_r  <= status_nxt;
    first_r   <= first_nxt;
  end

  // Next state and datapath.
  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    ptr_nxt     = ptr_r;
    end_nxt     = end_r;
    cand_nxt    = cand_r;
    run_nxt     = run_r;
    need_nxt    = need_r;
    cnt_nxt     = cnt_r;
    row_nxt     = row_r;
    wr_row_nxt  = wr_row_r;
    set_bit_nxt = set_bit_r;
    status_nxt  = status_r;
    first_nxt   = first_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + ROW_AW'(1);
        if (clr_r == ROW_AW'(NUM_ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          status_nxt = STATUS_DONE;
          first_nxt  = '0;
          unique case (in_op)
            OP_ALLOCATE: begin
              // The run starts as if the page below the scan start were in use.
              ptr_nxt  = scan_ext;
              cand_nxt = scan_ext;
              run_nxt  = '0;
              need_nxt = RUN_W'(in_count) + RUN_W'(1);
              cnt_nxt  = in_count;
              if (scan_ext >= map_end) begin
                status_nxt = STATUS_NO_SPACE;
                state_nxt  = ST_DONE;
              end else begin
                state_nxt = ST_SCAN_RD;
              end
            end
            OP_FREE, OP_MARK: begin
              ptr_nxt     = start_ext;
              end_nxt     = in_end;
              set_bit_nxt = (in_op == OP_MARK);
              if ((in_count == '0) || (start_ext >= map_end)) begin
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_SET_RD;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        ptr_nxt = ptr_inc;
        if (cur_bit) begin
          run_nxt  = '0;
          cand_nxt = ptr_inc;
        end else begin
          run_nxt = run_inc;
        end
        if (!cur_bit && (run_inc == need_r)) begin
          // Found: the first cnt_r pages of the run become present, the guard stays free.
          first_nxt   = cand_r[PAGE_W-1:0];
          ptr_nxt     = cand_r;
          end_nxt     = cand_r + PTR_W'(cnt_r);
          set_bit_nxt = 1'b1;
          state_nxt   = (cnt_r == '0) ? ST_DONE : ST_SET_RD;
        end else if (ptr_inc >= map_end) begin
          status_nxt = STATUS_NO_SPACE;
          state_nxt  = ST_DONE;
        end else if (row_last) begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SET_RD: begin
        state_nxt = ST_SET_LD;
      end
      ST_SET_LD: begin
        row_nxt    = map_rd_data;
        wr_row_nxt = ptr_row;
        state_nxt  = ST_SET;
      end
      ST_SET: begin
        row_nxt[bit_sel] = set_bit_r;
        ptr_nxt          = ptr_inc;
        if ((ptr_inc >= end_r) || (ptr_inc >= map_end) || row_last) begin
          state_nxt = ST_SET_WR;
        end
      end
      ST_SET_WR: begin
        // The next row is read in the same cycle as this one is written back.
        state_nxt = walk_end ? ST_DONE : ST_SET_LD;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    map_req         = '0;
    in_ready        = (state_r == ST_IDLE);
    res_valid       = (state_r == ST_DONE);
    res.status      = status_r;
    res.first_page  = first_r;
    unique case (state_r)
      ST_CLEAR: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_addr = clr_r;
        map_req.wr_data = '0;
      end
      ST_SCAN_RD, ST_SET_RD: begin
        map_req.rd_en   = 1'b1;
        map_req.rd_addr = ptr_row;
      end
      ST_SET_WR: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_addr = wr_row_r;
        map_req.wr_data = row_r;
        map_req.rd_en   = !walk_end;
        map_req.rd_addr = ptr_row;
      end
      default: begin
        map_req.rd_en = 1'b0;
      end
    endcase
  end

endmodule

/* design/contiguous_page_run_allocator.sv */
// Top level of the contiguous page run allocator: ports, scan start register, result register.
//
// A request beat on in_* carries operation, start_page and page_count. Allocate
// looks upward from the scan start register for page_count+1 free pages, marks
// the first page_count of them present and returns the first page; status 1
// means no such run exists. Free clears and mark sets the present bits of
// page_count pages from start_page; pages past the map are ignored.
// Every request gives exactly one result beat on out_*, in order.
// cfg_wr_en writes the scan start page (4096 after reset). The user must write it
// only while the block is idle; the block itself does not enforce this. The present
// map sits in a 2048 x 32 memory; the sequencer handles one request at a time and
// touches one page per cycle, pausing to read every row that a scan reads and to
// load and write back every row that a walk rewrites. Other requests finish
// without touching the map.
// After reset the block clears the map row by row with in_tready low.
// A result waits in the output register while out_tready is low, and one more
// request is accepted meanwhile; its result waits until the register is free.
module contiguous_page_run_allocator
  import cpra_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // operation [1:0], start_page [17:2], page_count [33:18], zero pad above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status [0], first_page [16:1], zero pad above
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [CFG_W-1:0]       scan_start_r;
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  map_req_t         map_req;
  logic [ROW_W-1:0] map_rd_data;
  logic             res_valid;
  logic             res_ready;
  result_t          res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_start_r <= SCAN_START_RESET;
    end else if (cfg_wr_en) begin
      scan_start_r <= cfg_wr_data;
    end
  end

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_tdata_r <= OUT_TDATA_W'({res.first_page, res.status});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  cpra_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (in_tdata[OP_W-1:0]),
    .in_start    (in_tdata[OP_W+PAGE_W-1:OP_W]),
    .in_count    (in_tdata[OP_W+PAGE_W+CNT_W-1:OP_W+PAGE_W]),
    .scan_start  (scan_start_r),
    .map_req     (map_req),
    .map_rd_data (map_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  cpra_map_ram u_map (
    .clk     (clk),
    .req     (map_req),
    .rd_data (map_rd_data)
  );

endmodule

/* design/cpra_checker.sv */
// Port-level checks of the allocator and the bind that attaches them.
module cpra_checker
  import cpra_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   cfg_wr_en,
  input logic [CFG_W-1:0]       cfg_wr_data,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // Reset empties the result register and starts the map clear.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("outputs not quiet after reset");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  // A failed allocation never reports a page.
  a_fail_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[PAGE_W:1] == '0)
    else $error("no-space result carries a page");

  // One request is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

endmodule

bind contiguous_page_run_allocator cpra_checker u_cpra_checker (.*);
